// ===== rtl/xrg_pkg.sv =====
`timescale 1ns / 1ps

package xrg_pkg;

  // Generator seeds, loaded at reset.
  localparam logic [31:0] SEED_A = 32'd123456789;
  localparam logic [31:0] SEED_B = 32'd362436069;
  localparam logic [31:0] SEED_C = 32'd521288629;
  localparam logic [31:0] SEED_D = 32'd88675123;

  // Shift amounts of one xorshift128 step.
  localparam int unsigned SHIFT_L = 11;
  localparam int unsigned SHIFT_W = 19;
  localparam int unsigned SHIFT_T = 8;

  localparam int unsigned HALF_BITS = 32;

  typedef enum logic [2:0] {
    OP_RAW32     = 3'd0,
    OP_HALF_OPEN = 3'd1,
    OP_CLOSED    = 3'd2,
    OP_RAW64     = 3'd3,
    OP_PAIR      = 3'd4
  } op_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } xs_state_t;

  // One request as held in the input register.
  typedef struct packed {
    op_e                op;
    logic signed [31:0] range_begin;
    logic signed [31:0] range_end;
  } req_t;

  // Tells the state module whether and how far to advance.
  typedef struct packed {
    logic advance;
    logic two;
  } step_ctl_t;

  // Contents of the product register.
  typedef struct packed {
    op_e         op;
    logic        err;
    logic [31:0] range_begin;
    logic [32:0] span;
    logic [32:0] off_u;
    logic [31:0] off_v;
    logic [63:0] raw;
  } prod_t;

  function automatic xs_state_t xs_step(input xs_state_t s);
    logic [31:0] t;
    xs_state_t   n;
    t   = s.a ^ (s.a << SHIFT_L);
    n.a = s.b;
    n.b = s.c;
    n.c = s.d;
    n.d = s.d ^ (s.d >> SHIFT_W) ^ t ^ (t >> SHIFT_T);
    return n;
  endfunction

endpackage

// ===== rtl/xrg_state.sv =====
`timescale 1ns / 1ps

// Holds the four generator words and offers the next two draws.
module xrg_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xrg_pkg::step_ctl_t    ctl_i,
  output logic [31:0]           draw1_o,
  output logic [31:0]           draw2_o
);

  xrg_pkg::xs_state_t state_q, state_d;
  xrg_pkg::xs_state_t state1, state2;

  always_comb begin
    state1 = xrg_pkg::xs_step(state_q);
    state2 = xrg_pkg::xs_step(state1);
    if (ctl_i.advance) begin
      state_d = ctl_i.two ? state2 : state1;
    end else begin
      state_d = state_q;
    end
  end

  assign draw1_o = state1.d;
  assign draw2_o = state2.d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.a <= xrg_pkg::SEED_A;
      state_q.b <= xrg_pkg::SEED_B;
      state_q.c <= xrg_pkg::SEED_C;
      state_q.d <= xrg_pkg::SEED_D;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/xrg_product_stage.sv =====
`timescale 1ns / 1ps

// Checks the bounds, takes the draws and forms the scaled products.
module xrg_product_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  xrg_pkg::req_t        req_i,
  output logic                 ready_o,
  output xrg_pkg::step_ctl_t   step_ctl_o,
  input  logic [31:0]          draw1_i,
  input  logic [31:0]          draw2_i,
  output logic                 valid_o,
  output xrg_pkg::prod_t       prod_o,
  input  logic                 out_ready_i
);

  logic                  valid_q;
  xrg_pkg::prod_t        prod_q, prod_d;
  logic signed [32:0]    diff;
  logic                  err;
  logic [32:0]           span;
  logic [31:0]           span_m1;
  logic [64:0]           prod1;
  logic [63:0]           prod2;
  logic                  fire;

  // Exact width of the range; it cannot wrap in 33 bits.
  assign diff = {req_i.range_end[31], req_i.range_end}
              - {req_i.range_begin[31], req_i.range_begin};

  always_comb begin
    unique case (req_i.op) inside
      xrg_pkg::OP_RAW32, xrg_pkg::OP_RAW64: err = 1'b0;
      xrg_pkg::OP_HALF_OPEN:                err = (diff <= 33'sd0);
      xrg_pkg::OP_CLOSED:                   err = (diff < 33'sd0);
      xrg_pkg::OP_PAIR:                     err = (diff < 33'sd2);
      default:                              err = 1'b1;
    endcase
  end

  // A closed range holds one more value; a full closed range spans 2^32.
  assign span    = (req_i.op == xrg_pkg::OP_CLOSED) ? 33'(diff + 33'sd1) : 33'(diff);
  assign span_m1 = 32'(span - 33'd1);

  assign prod1 = 65'(draw1_i) * 65'(span);
  assign prod2 = 64'(draw2_i) * 64'(span_m1);

  always_comb begin
    prod_d.op          = req_i.op;
    prod_d.err         = err;
    prod_d.range_begin = req_i.range_begin;
    prod_d.span        = span;
    prod_d.off_u       = prod1[64:xrg_pkg::HALF_BITS];
    prod_d.off_v       = prod2[63:xrg_pkg::HALF_BITS];
    case (req_i.op)
      xrg_pkg::OP_RAW32: prod_d.raw = {32'd0, draw1_i};
      xrg_pkg::OP_RAW64: prod_d.raw = {draw1_i, draw2_i};
      default:           prod_d.raw = 64'd0;
    endcase
  end

  assign ready_o = !valid_q || out_ready_i;
  assign fire    = in_valid_i && ready_o;

  // A rejected request leaves the generator untouched.
  assign step_ctl_o.advance = fire && !err;
  assign step_ctl_o.two     = (req_i.op == xrg_pkg::OP_RAW64) || (req_i.op == xrg_pkg::OP_PAIR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== rtl/xrg_result_stage.sv =====
`timescale 1ns / 1ps

// Adds the offsets to the lower bound, builds the ordered pair and holds
// the finished result until the receiver takes it.
module xrg_result_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  xrg_pkg::prod_t    prod_i,
  output logic              ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [127:0]      m_axis_tdata,
  output logic              m_axis_tuser
);

  logic          valid_q;
  logic [127:0]  data_q, data_d;
  logic          err_q;
  logic [31:0]   ou;
  logic [33:0]   ov_sum;
  logic [31:0]   ov;
  logic [31:0]   lo_off, hi_off;
  logic [31:0]   first, second;
  logic          fire;

  // The second pair member is offset from the first by 1 .. span-1,
  // wrapped back into the range.
  always_comb begin
    ou     = prod_i.off_u[31:0];
    ov_sum = 34'(prod_i.off_u) + 34'd1 + 34'(prod_i.off_v);
    if (ov_sum >= 34'(prod_i.span)) begin
      ov = 32'(ov_sum - 34'(prod_i.span));
    end else begin
      ov = ov_sum[31:0];
    end
    if (ou < ov) begin
      lo_off = ou;
      hi_off = ov;
    end else begin
      lo_off = ov;
      hi_off = ou;
    end
  end

  always_comb begin
    first  = 32'd0;
    second = 32'd0;
    case (prod_i.op) inside
      xrg_pkg::OP_HALF_OPEN, xrg_pkg::OP_CLOSED: begin
        first = prod_i.range_begin + prod_i.off_u[31:0];
      end
      xrg_pkg::OP_PAIR: begin
        first  = prod_i.range_begin + lo_off;
        second = prod_i.range_begin + hi_off;
      end
      default: begin
        first  = 32'd0;
        second = 32'd0;
      end
    endcase
    if (prod_i.err) begin
      data_d = 128'd0;
    end else begin
      data_d = {second, first, prod_i.raw};
    end
  end

  assign ready_o = !valid_q || m_axis_tready;
  assign fire    = in_valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q <= data_d;
      err_q  <= prod_i.err;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = err_q;

endmodule

// ===== rtl/xorshift_range_generator.sv =====
`timescale 1ns / 1ps

// xorshift128 random source with range reduction.
//
// Each beat on the slave channel is one request: the operation code in
// s_axis_tuser and the signed bounds in s_axis_tdata. Each request gives
// exactly one beat on the master channel: the raw draw, one ranged value or
// an ordered distinct pair in m_axis_tdata, and an error flag in
// m_axis_tuser. A rejected request returns zeros and does not advance the
// generator.
//
// The request passes three registers: the input register, the product
// register (draws and the 32x33 and 32x32 multiplies) and the result register.
// One request is taken every cycle while the receiver does not stall; at
// most two xorshift steps are chained ahead of the product register, so a
// 64-bit draw or a pair moves through like any other request.
//
// Reset loads the four fixed seeds and empties all three registers.
// When the receiver stalls, the result holds steady and the earlier stages
// keep filling until every register is full; only then does s_axis_tready
// drop.
module xorshift_range_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // range_begin [31:0], range_end [63:32]
  input  logic [2:0]    s_axis_tuser,   // operation [2:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // raw_bits [63:0], first_value [95:64],
                                        // second_value [127:96]
  output logic          m_axis_tuser    // range_error [0]
);

  logic                 in_valid_q;
  xrg_pkg::req_t        req_q, req_d;
  logic                 prod_ready;
  logic                 prod_valid;
  xrg_pkg::prod_t       prod;
  logic                 res_ready;
  xrg_pkg::step_ctl_t   step_ctl;
  logic [31:0]          draw1, draw2;
  logic                 in_fire;

  // Input register: takes a new beat whenever it is empty or draining.
  assign s_axis_tready = !in_valid_q || prod_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign req_d.op          = xrg_pkg::op_e'(s_axis_tuser);
  assign req_d.range_begin = s_axis_tdata[31:0];
  assign req_d.range_end   = s_axis_tdata[63:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
  end

  // The generator words move only when a request enters the product stage,
  // so draws are handed out strictly in request order.
  xrg_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (step_ctl),
    .draw1_o (draw1),
    .draw2_o (draw2)
  );

  xrg_product_stage u_product (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .req_i       (req_q),
    .ready_o     (prod_ready),
    .step_ctl_o  (step_ctl),
    .draw1_i     (draw1),
    .draw2_i     (draw2),
    .valid_o     (prod_valid),
    .prod_o      (prod),
    .out_ready_i (res_ready)
  );

  xrg_result_stage u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (prod_valid),
    .prod_i        (prod),
    .ready_o       (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/xrg_checker.sv =====
`timescale 1ns / 1ps

// Watches the ports of the generator.
module xrg_sva (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,
  input  logic [2:0]    s_axis_tuser,
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [127:0]  m_axis_tdata,
  input  logic          m_axis_tuser
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // With the output empty, nothing upstream may be blocked.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register is empty");

  // A rejected request carries only zeros.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 128'd0)
    else $error("rejected request returned nonzero data");

  // A nonzero second value only comes from a pair, which is strictly ordered.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[127:96] != 32'd0) |->
      ($signed(m_axis_tdata[95:64]) < $signed(m_axis_tdata[127:96]))
      && (m_axis_tdata[63:0] == 64'd0))
    else $error("pair not distinct and ascending");

endmodule

bind xorshift_range_generator xrg_sva u_xrg_sva (.*);
